[src/nmr_pkg.sv]
`default_nettype none

package nmr_pkg;

    // field and state widths
    localparam int NOISE_W  = 32;
    localparam int EXC_W    = 32;
    localparam int WGT_W    = 16;
    localparam int RATIO_W  = 32;
    localparam int DEN_W    = WGT_W + EXC_W;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 8;
    localparam int STEP_W   = 6;

    // frame limits
    localparam int MAX_BANDS        = 128;
    localparam logic [CNT_W-1:0] BAND_COUNT_RESET = CNT_W'(109);
    localparam logic [CNT_W-1:0] BAND_COUNT_MAX   = CNT_W'(MAX_BANDS);

    // last step index of each divider run
    localparam logic [STEP_W-1:0] RATIO_LAST_STEP = STEP_W'(RATIO_W - 1);
    localparam logic [STEP_W-1:0] MEAN_LAST_STEP  = STEP_W'(SUM_W - 1);

    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

    // control from the sequencer to the shared divider
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

`default_nettype wire

[src/frame_noise_to_mask_ratio_unit.sv]
// Frame noise-to-mask ratio unit.
// Input channel (i_in_valid / o_in_ready) takes one critical band per item:
// noise energy, excitation energy (UQ16.16) and mask weight (UQ0.16).
// The band ratio noise / (weight * excitation) is formed in UQ16.16 and
// saturates to all ones on overflow or a zero denominator.
// Output channel (o_out_valid / i_out_ready) gives one item per frame:
// mean and peak ratio and a saturation flag, after band_count bands.
// Config channel (i_cfg_valid / o_cfg_ready) writes band_count; always ready.
// Between accept and ready again a band passes a multiply state, a check
// state, 32 steps of the shared restoring divider and an accumulate state;
// a band whose ratio saturates skips the divider. The last band of a frame
// adds 40 divider steps for the mean and then an output load state.
// The output register holds a result until taken; the block keeps taking
// bands while it waits and only stalls when the next frame result is ready.
// Reset (synchronous, active low) clears the frame state, drops o_out_valid
// and sets band_count to 109.
`default_nettype none

module frame_noise_to_mask_ratio_unit
    import nmr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // band items
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [NOISE_W-1:0] i_noise_energy,
    input  wire logic [EXC_W-1:0]   i_excitation_energy,
    input  wire logic [WGT_W-1:0]   i_mask_weight,
    // frame results
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [RATIO_W-1:0]      o_nmr_mean,
    output logic [RATIO_W-1:0]      o_nmr_peak,
    output logic                    o_saturated,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CNT_W-1:0]   i_cfg_band_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_ACC,
        S_MEAN,
        S_OUT
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]   r_band_count;
    logic [NOISE_W-1:0] r_noise;
    logic [EXC_W-1:0]   r_exc;
    logic [WGT_W-1:0]   r_weight;
    logic [DEN_W-1:0]   r_den;
    logic               r_sat_band;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_sum;
    logic [RATIO_W-1:0] r_peak;
    logic               r_sat_seen;
    logic [CNT_W-1:0]   r_index;
    logic               r_out_valid;
    logic [RATIO_W-1:0] r_mean_out;
    logic [RATIO_W-1:0] r_peak_out;
    logic               r_sat_out;

    logic [DEN_W-1:0]   w_prod;
    logic               w_band_sat;
    logic [RATIO_W-1:0] w_ratio;
    logic [SUM_W-1:0]   n_sum;
    logic [RATIO_W-1:0] n_peak;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_last;
    t_div_ctl           w_div_ctl;
    logic [DEN_W-1:0]   w_rem_init;
    logic [SUM_W-1:0]   w_quo_init;
    logic [DEN_W-1:0]   w_divisor;
    logic [SUM_W-1:0]   w_quo;

    // shared divider
    nmr_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_rem_init (w_rem_init),
        .i_quo_init (w_quo_init),
        .i_divisor  (w_divisor),
        .o_quo      (w_quo)
    );

    // denominator product, check for zero or overflow
    always_comb begin
        w_prod     = r_weight * r_exc;
        w_band_sat = (r_den == '0) || ({{(DEN_W-NOISE_W){1'b0}}, r_noise} >= r_den);
    end

    // band ratio, accumulation and frame end
    always_comb begin
        w_ratio = r_sat_band ? RATIO_SAT : w_quo[RATIO_W-1:0];
        n_sum   = r_sum + SUM_W'(w_ratio);
        n_peak  = (w_ratio > r_peak) ? w_ratio : r_peak;
        if (r_band_count == '0) begin
            w_cnt = CNT_W'(1);
        end else if (r_band_count > BAND_COUNT_MAX) begin
            w_cnt = BAND_COUNT_MAX;
        end else begin
            w_cnt = r_band_count;
        end
        w_last = ({1'b0, r_index} + (CNT_W+1)'(1)) >= {1'b0, w_cnt};
    end

    // divider load and step selection
    always_comb begin
        w_div_ctl.load = 1'b0;
        w_div_ctl.step = 1'b0;
        w_rem_init     = '0;
        w_quo_init     = n_sum;
        w_divisor      = DEN_W'(w_cnt);
        case (r_state)
            S_CHK: begin
                w_div_ctl.load = ~w_band_sat;
                w_rem_init     = DEN_W'(r_noise);
                w_quo_init     = '0;
                w_divisor      = r_den;
            end
            S_ACC: begin
                w_div_ctl.load = w_last;
            end
            S_DIV, S_MEAN: begin
                w_div_ctl.step = 1'b1;
            end
            default: begin
                w_div_ctl.load = 1'b0;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count <= BAND_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_band_count <= i_cfg_band_count;
        end
    end

    // sequencer with frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_peak      <= '0;
            r_sat_seen  <= 1'b0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // the output load below takes over when a taken item is replaced
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_noise  <= i_noise_energy;
                        r_exc    <= i_excitation_energy;
                        r_weight <= i_mask_weight;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_den   <= w_prod;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_sat_band <= w_band_sat;
                    r_step     <= '0;
                    r_state    <= w_band_sat ? S_ACC : S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == RATIO_LAST_STEP) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum      <= n_sum;
                    r_peak     <= n_peak;
                    r_sat_seen <= r_sat_seen | r_sat_band;
                    r_step     <= '0;
                    if (w_last) begin
                        r_state <= S_MEAN;
                    end else begin
                        r_index <= r_index + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_MEAN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == MEAN_LAST_STEP) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for the previous frame item to leave
                    if (!r_out_valid || i_out_ready) begin
                        r_mean_out  <= w_quo[RATIO_W-1:0];
                        r_peak_out  <= r_peak;
                        r_sat_out   <= r_sat_seen;
                        r_out_valid <= 1'b1;
                        r_sum       <= '0;
                        r_peak      <= '0;
                        r_sat_seen  <= 1'b0;
                        r_index     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_nmr_mean  = r_mean_out;
    assign o_nmr_peak  = r_peak_out;
    assign o_saturated = r_sat_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[src/nmr_div.sv]
`default_nettype none

module nmr_div
    import nmr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [DEN_W-1:0] i_rem_init,
    input  wire logic [SUM_W-1:0] i_quo_init,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic      [SUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_dvs;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W+1:0] w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;
    logic [SUM_W-1:0] n_quo;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        w_shift = {r_rem, r_quo[SUM_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_ge    = ~w_diff[DEN_W+1];
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        n_quo   = {r_quo[SUM_W-2:0], w_ge};
    end

    // working registers, loaded by the sequencer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_rem_init;
            r_quo <= i_quo_init;
            r_dvs <= i_divisor;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

[src/nmr_checker.sv]
`default_nettype none

module nmr_checker
    import nmr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [RATIO_W-1:0] o_nmr_mean,
    input  wire logic [RATIO_W-1:0] o_nmr_peak,
    input  wire logic               o_saturated
);

    // after reset nothing is pending and the band side is open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");

    // the band side closes once a band item is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after a band item");

    // a saturated band always sets the peak to full scale
    a_sat_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_nmr_peak == RATIO_SAT))
        else $error("saturated frame without full-scale peak");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_nmr_mean) && $stable(o_nmr_peak)
             && $stable(o_saturated)))
        else $error("result item changed while stalled");

endmodule

bind frame_noise_to_mask_ratio_unit nmr_checker u_nmr_checker (.*);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nmr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_BANDS   = 125;
    localparam int NUM_PHASES    = 12;

    typedef struct packed {
        logic [NOISE_W-1:0] noise;
        logic [EXC_W-1:0]   excitation;
        logic [WGT_W-1:0]   weight;
    } t_band;

    typedef struct packed {
        logic [RATIO_W-1:0] mean;
        logic [RATIO_W-1:0] peak;
        logic               saturated;
    } t_frame_result;

    // band counts of the random phases, four per idling mode
    int unsigned phase_band_count [NUM_PHASES] = '{3, 128, 1, 17, 255, 7, 0, 64, 2, 109, 31, 128};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid  = 1'b0;
    logic [NOISE_W-1:0] in_noise  = '0;
    logic [EXC_W-1:0]   in_exc    = '0;
    logic [WGT_W-1:0]   in_weight = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CNT_W-1:0]   cfg_count = '0;

    wire logic               o_in_ready;
    wire logic               o_out_valid;
    wire logic [RATIO_W-1:0] o_nmr_mean;
    wire logic [RATIO_W-1:0] o_nmr_peak;
    wire logic               o_saturated;
    wire logic               o_cfg_ready;

    // pending band items and expected frame results
    t_band         band_q[$];
    t_frame_result nmr_expected[$];

    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // shadow of the frame state and the band count register
    logic [CNT_W-1:0]   band_count_shadow = BAND_COUNT_RESET;
    logic [SUM_W-1:0]   ratio_total = '0;
    logic [RATIO_W-1:0] ratio_max   = '0;
    int unsigned        band_pos    = 0;
    logic               sat_seen    = 1'b0;

    frame_noise_to_mask_ratio_unit u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_noise_energy      (in_noise),
        .i_excitation_energy (in_exc),
        .i_mask_weight       (in_weight),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_nmr_mean          (o_nmr_mean),
        .o_nmr_peak          (o_nmr_peak),
        .o_saturated         (o_saturated),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_band_count    (cfg_count)
    );

    // clock
    always #6 clk = ~clk;

    // band ratio noise / (weight * excitation) in UQ16.16, saturating
    function automatic logic [RATIO_W-1:0] band_nmr(input t_band b, output logic sat);
        logic [DEN_W-1:0]   den;
        logic [63:0]        num;
        logic [63:0]        quo;
        logic [RATIO_W-1:0] r;
        den = DEN_W'(b.weight) * DEN_W'(b.excitation);
        num = {b.noise, 32'd0};
        sat = 1'b0;
        r   = RATIO_SAT;
        if (den == '0) begin
            sat = 1'b1;
        end else begin
            quo = num / 64'(den);
            if (quo > 64'h0000_0000_FFFF_FFFF) begin
                sat = 1'b1;
            end else begin
                r = quo[RATIO_W-1:0];
            end
        end
        return r;
    endfunction

    // fold one band into the frame, closing the frame on its last band
    task automatic accumulate_band(input t_band b);
        logic [RATIO_W-1:0] r;
        logic               s;
        int unsigned        cnt;
        t_frame_result      res;
        r   = band_nmr(b, s);
        cnt = band_count_shadow;
        if (cnt == 0) cnt = 1;
        if (cnt > MAX_BANDS) cnt = MAX_BANDS;
        ratio_total = ratio_total + SUM_W'(r);
        if (r > ratio_max) ratio_max = r;
        if (s) sat_seen = 1'b1;
        if (band_pos + 1 >= cnt) begin
            res.mean      = RATIO_W'(ratio_total / SUM_W'(cnt));
            res.peak      = ratio_max;
            res.saturated = sat_seen;
            nmr_expected.push_back(res);
            ratio_total = '0;
            ratio_max   = '0;
            band_pos    = 0;
            sat_seen    = 1'b0;
        end else begin
            band_pos = (band_pos + 1) & 32'hFF;
        end
    endtask

    // random band: mostly moderate ratios, some zero or tiny denominators
    function automatic t_band random_band();
        t_band b;
        b.noise      = NOISE_W'($urandom);
        b.excitation = EXC_W'($urandom);
        b.weight     = WGT_W'($urandom);
        case ($urandom_range(9))
            0: begin
            end
            1: begin
                if ($urandom_range(1) == 0) b.weight = '0;
                else b.excitation = '0;
            end
            2: begin
                b.excitation = b.excitation >> $urandom_range(16, 31);
                b.weight     = b.weight >> $urandom_range(8, 15);
            end
            default: begin
                b.noise      = b.noise >> $urandom_range(0, 31);
                b.excitation = b.excitation >> $urandom_range(0, 24);
            end
        endcase
        return b;
    endfunction

    task automatic push_band(input logic [NOISE_W-1:0] noise,
                             input logic [EXC_W-1:0] excitation,
                             input logic [WGT_W-1:0] weight);
        t_band b;
        b.noise      = noise;
        b.excitation = excitation;
        b.weight     = weight;
        band_q.push_back(b);
    endtask

    // hold off until every band is taken and every frame result is back
    task automatic wait_idle();
        while (band_q.size() != 0 || in_valid) @(posedge clk);
        while (nmr_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_band_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_count <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        band_count_shadow = value;
    endtask

    // band driver
    always @(posedge clk) begin : drive_bands
        t_band cur;
        t_band nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                cur.noise      = in_noise;
                cur.excitation = in_exc;
                cur.weight     = in_weight;
                accumulate_band(cur);
            end
            if (!in_valid || o_in_ready) begin
                if (band_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = band_q.pop_front();
                    in_valid  <= 1'b1;
                    in_noise  <= nxt.noise;
                    in_exc    <= nxt.excitation;
                    in_weight <= nxt.weight;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // frame result monitor
    always @(posedge clk) begin : check_frames
        t_frame_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (nmr_expected.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected frame result: mean %h peak %h sat %b",
                                 o_nmr_mean, o_nmr_peak, o_saturated);
                    mismatch_count++;
                end else begin
                    want = nmr_expected.pop_front();
                    if (o_nmr_mean !== want.mean || o_nmr_peak !== want.peak ||
                        o_saturated !== want.saturated) begin
                        if (mismatch_count < 10)
                            $display("frame mismatch: mean %h/%h peak %h/%h sat %b/%b (got/exp)",
                                     o_nmr_mean, want.mean, o_nmr_peak, want.peak,
                                     o_saturated, want.saturated);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int mode;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_pct  = 23;
        out_idle_pct = 60;

        // one band per frame: field extremes and saturation corners
        write_band_count(8'd1);
        push_band(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        push_band(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_band(32'h1234_5678, 32'h0001_0000, 16'h0000);
        push_band(32'h1234_5678, 32'h0000_0000, 16'h8000);
        push_band(32'h0000_0000, 32'h0000_0000, 16'h0000);
        push_band(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001);
        // quotient one past the top, then just under it
        push_band(32'hFFFF_FFFF, 32'h0001_0001, 16'hFFFF);
        push_band(32'hFFFF_FFFE, 32'h0001_0001, 16'hFFFF);
        // exactly all ones without overflow
        push_band(32'hFFFF_FFFF, 32'h0002_0000, 16'h8000);
        push_band(32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF);
        push_band(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        push_band(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
        push_band(32'h0001_0000, 32'h0001_0000, 16'h8000);
        wait_idle();

        // count of zero acts as one
        write_band_count(8'd0);
        push_band(32'h0003_0000, 32'h0001_0000, 16'hFFFF);
        push_band(32'h0000_8000, 32'h0004_0000, 16'h4000);
        wait_idle();

        // short frame with a saturated band inside
        write_band_count(8'd4);
        push_band(32'h0002_0000, 32'h0001_0000, 16'h8000);
        push_band(32'h0010_0000, 32'h0000_0000, 16'h1000);
        push_band(32'h0000_4000, 32'h0002_0000, 16'hC000);
        push_band(32'h0100_0000, 32'h0040_0000, 16'h2000);
        wait_idle();

        // count lowered mid-frame closes the frame on the next band
        write_band_count(8'd8);
        repeat (5) band_q.push_back(random_band());
        wait_idle();
        write_band_count(8'd3);
        push_band(32'h0005_0000, 32'h0001_0000, 16'hFFFF);
        push_band(32'h0000_1000, 32'h0001_0000, 16'h0100);
        wait_idle();

        // random phases over the idling modes and band counts
        for (int p = 0; p < NUM_PHASES; p++) begin
            mode = p / 4;
            case (mode)
                0: begin
                    in_idle_pct  = 23;
                    out_idle_pct = 60;
                end
                1: begin
                    in_idle_pct  = 60;
                    out_idle_pct = 23;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            write_band_count(CNT_W'(phase_band_count[p]));
            repeat (PHASE_BANDS) band_q.push_back(random_band());
            wait_idle();
        end

        if (mismatch_count == 0 && nmr_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[frame_noise_to_mask_ratio_unit.f]
src/nmr_pkg.sv
src/nmr_div.sv
src/frame_noise_to_mask_ratio_unit.sv
src/nmr_checker.sv
bench/tb.sv
